FILE: sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types for the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned FrameLen = 25;
  localparam int unsigned NumCh    = 10;
  localparam int unsigned NumSw    = 6;
  localparam int unsigned NumStick = 4;
  localparam int unsigned FlagsIdx = 23;
  localparam int unsigned ChW      = 11;
  localparam int unsigned ValW     = 12;
  localparam int unsigned PosW     = 5;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;
  // Channel payload: bytes 1..14 carry the ten packed channels
  localparam int unsigned PackBytes = 14;

  localparam logic [7:0] FailsafeA = 8'h0C;
  localparam logic [7:0] FailsafeB = 8'h0F;

  localparam logic [7:0]     HeadReset   = 8'h0F;
  localparam logic [7:0]     EndReset    = 8'h00;
  localparam logic [ChW-1:0] OffsetReset = 11'h400;
  localparam logic [ChW-1:0] UpReset     = 11'h161;
  localparam logic [ChW-1:0] MidReset    = 11'h400;
  localparam logic [ChW-1:0] DownReset   = 11'h69F;

  typedef enum logic [1:0] {
    SwUnset = 2'd0,
    SwUp    = 2'd1,
    SwMid   = 2'd2,
    SwDown  = 2'd3
  } sw_pos_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHead   = 3'd0,
    CfgEnd    = 3'd1,
    CfgOffset = 3'd2,
    CfgUp     = 3'd3,
    CfgMid    = 3'd4,
    CfgDown   = 3'd5
  } cfg_reg_e;

endpackage

FILE: sv/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Collects 25-byte SBUS frames, checks head and end bytes, unpacks ten
// channels and the held switch positions, and emits one result per channel.
// ----------------------------------------------------------------------------
// A received byte is taken every cycle unless the input register is held. It
// lands in an input register and is stored into the frame registers when it
// advances. The 25th byte of a frame with matching head and end bytes, or any
// link-lost byte, loads a result buffer that then drains ten results, channel
// 0 to 9, one per cycle while out_ready_i is high. Bytes that cause no results
// pass at one per cycle even while a burst drains; a byte that starts a new
// burst waits in the input register until the last result of the current
// burst is taken.
module sbus_frame_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [7:0]                           rx_byte_i,
  input  logic                                 frame_start_i,
  input  logic                                 link_lost_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sfd_pkg::IdxW-1:0]             channel_index_o,
  output logic signed [sfd_pkg::ValW-1:0]      channel_value_o,
  output logic [1:0]                           switch_position_o,
  output logic                                 online_o,
  output logic                                 last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sfd_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [sfd_pkg::CfgDataW-1:0]         cfg_data_i
);

  localparam int unsigned ChW  = sfd_pkg::ChW;
  localparam int unsigned ValW = sfd_pkg::ValW;
  localparam int unsigned PosW = sfd_pkg::PosW;
  localparam int unsigned IdxW = sfd_pkg::IdxW;

  // configuration registers
  logic [7:0]     head_q, end_q;
  logic [ChW-1:0] offset_q, up_q, mid_q, down_q;

  // input register
  logic       in_vld_q;
  logic [7:0] rx_q;
  logic       start_q, lost_q;

  // frame state
  logic [7:0]          frame_q [sfd_pkg::FrameLen];
  logic [PosW-1:0]     pos_q, pos_d, pos_eff;
  sfd_pkg::sw_pos_e    sw_q [sfd_pkg::NumSw];
  sfd_pkg::sw_pos_e    sw_d [sfd_pkg::NumSw];

  // result buffer
  logic                 busy_q;
  logic [IdxW-1:0]      cnt_q;
  logic [ValW-1:0]      vals_q [sfd_pkg::NumCh];
  logic [ValW-1:0]      vals_d [sfd_pkg::NumCh];
  sfd_pkg::sw_pos_e     bsw_q [sfd_pkg::NumSw];
  logic                 online_q, online_d;

  logic                 store_en;
  logic                 good_frame, emit, burst_free, advance, out_fire;
  logic [8*sfd_pkg::PackBytes-1:0] packed_bits;
  logic [ChW-1:0]       ch [sfd_pkg::NumCh];
  logic [7:0]           flags;
  logic [2:0]           sw_idx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= sfd_pkg::HeadReset;
      end_q    <= sfd_pkg::EndReset;
      offset_q <= sfd_pkg::OffsetReset;
      up_q     <= sfd_pkg::UpReset;
      mid_q    <= sfd_pkg::MidReset;
      down_q   <= sfd_pkg::DownReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sfd_pkg::CfgHead:   head_q   <= cfg_data_i[7:0];
        sfd_pkg::CfgEnd:    end_q    <= cfg_data_i[7:0];
        sfd_pkg::CfgOffset: offset_q <= cfg_data_i;
        sfd_pkg::CfgUp:     up_q     <= cfg_data_i;
        sfd_pkg::CfgMid:    mid_q    <= cfg_data_i;
        sfd_pkg::CfgDown:   down_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // byte handling of the held item
  // --------------------------------------------------------------------------
  always_comb begin
    pos_eff  = start_q ? '0 : pos_q;
    store_en = 1'b0;
    pos_d    = pos_q;
    if (!lost_q && (pos_eff < PosW'(sfd_pkg::FrameLen))) begin
      store_en = 1'b1;
      pos_d    = pos_eff + PosW'(1);
    end else if (!lost_q) begin
      pos_d = pos_eff;
    end
  end

  // byte 24 is the held byte itself; the rest are already stored
  assign good_frame = store_en && (pos_eff == PosW'(sfd_pkg::FrameLen - 1)) &&
                      (frame_q[0] == head_q) && (rx_q == end_q);
  assign emit = lost_q || good_frame;

  assign out_fire   = busy_q && out_ready_i;
  assign burst_free = !busy_q || (out_fire && (cnt_q == IdxW'(sfd_pkg::NumCh - 1)));
  assign advance    = in_vld_q && (!emit || burst_free);
  assign in_ready_o = !in_vld_q || advance;

  // --------------------------------------------------------------------------
  // channel unpack and switch decode
  // --------------------------------------------------------------------------
  always_comb begin
    for (int b = 0; b < sfd_pkg::PackBytes; b++) begin
      packed_bits[8*b +: 8] = frame_q[b+1];
    end
    for (int k = 0; k < sfd_pkg::NumCh; k++) begin
      ch[k] = packed_bits[ChW*k +: ChW];
    end
  end

  assign flags    = frame_q[sfd_pkg::FlagsIdx];
  assign online_d = !lost_q && (flags != sfd_pkg::FailsafeA) && (flags != sfd_pkg::FailsafeB);

  always_comb begin
    for (int k = 0; k < sfd_pkg::NumSw; k++) begin
      sw_d[k] = sw_q[k];
      if (lost_q) begin
        sw_d[k] = sfd_pkg::SwUnset;
      end else if (ch[k+sfd_pkg::NumStick] == up_q) begin
        sw_d[k] = sfd_pkg::SwUp;
      end else if ((k < 4) && (ch[k+sfd_pkg::NumStick] == mid_q)) begin
        sw_d[k] = sfd_pkg::SwMid;
      end else if (ch[k+sfd_pkg::NumStick] == down_q) begin
        sw_d[k] = sfd_pkg::SwDown;
      end
    end
    for (int k = 0; k < sfd_pkg::NumCh; k++) begin
      if (lost_q) begin
        vals_d[k] = '0;
      end else if (k < sfd_pkg::NumStick) begin
        vals_d[k] = {1'b0, ch[k]} - {1'b0, offset_q};
      end else begin
        vals_d[k] = {1'b0, ch[k]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rx_q    <= rx_byte_i;
      start_q <= frame_start_i;
      lost_q  <= link_lost_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && store_en) begin
      frame_q[pos_eff] <= rx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int k = 0; k < sfd_pkg::NumSw; k++) begin
        sw_q[k] <= sfd_pkg::SwUnset;
      end
    end else if (advance) begin
      pos_q <= pos_d;
      if (emit) begin
        for (int k = 0; k < sfd_pkg::NumSw; k++) begin
          sw_q[k] <= sw_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (advance && emit) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (out_fire) begin
      if (cnt_q == IdxW'(sfd_pkg::NumCh - 1)) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        cnt_q <= cnt_q + IdxW'(1);
      end
    end
  end

  // snapshot of one burst; held while it drains
  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      vals_q   <= vals_d;
      bsw_q    <= sw_d;
      online_q <= online_d;
    end
  end

  // --------------------------------------------------------------------------
  // result channel
  // --------------------------------------------------------------------------
  assign sw_idx            = 3'(cnt_q - IdxW'(sfd_pkg::NumStick));
  assign out_valid_o       = busy_q;
  assign channel_index_o   = cnt_q;
  assign channel_value_o   = vals_q[cnt_q];
  assign switch_position_o = (cnt_q < IdxW'(sfd_pkg::NumStick)) ? sfd_pkg::SwUnset
                                                                 : bsw_q[sw_idx];
  assign online_o          = online_q;
  assign last_o            = (cnt_q == IdxW'(sfd_pkg::NumCh - 1));

endmodule

FILE: test/sbus_frame_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder_tb
// Self-checking bench for the SBUS frame decoder. A queue of received bytes
// feeds a handshake driver. Each accepted byte runs through a behavioral
// decoder that predicts the channel results. A monitor takes the results under
// random back-pressure and compares each one with the oldest prediction.
// Register settings change between phases, only while the decoder is idle.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_tb;
  import sfd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       lost;
  } rx_item_t;

  typedef struct packed {
    logic [IdxW-1:0] chan;
    logic [ValW-1:0] value;
    sw_pos_e         position;
    logic            online;
    logic            last;
  } chan_result_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_ready_o;
  logic [7:0]                   rx_byte_i     = 8'h00;
  logic                         frame_start_i = 1'b0;
  logic                         link_lost_i   = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i   = 1'b0;
  logic [IdxW-1:0]              channel_index_o;
  logic signed [ValW-1:0]       channel_value_o;
  logic [1:0]                   switch_position_o;
  logic                         online_o;
  logic                         last_o;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [CfgIdxW-1:0]           cfg_index_i   = '0;
  logic [CfgDataW-1:0]          cfg_data_i    = '0;

  // Decoder state as seen by the bench
  logic [7:0]     cfg_head   = HeadReset;
  logic [7:0]     cfg_tail   = EndReset;
  logic [ChW-1:0] cfg_offset = OffsetReset;
  logic [ChW-1:0] cfg_up     = UpReset;
  logic [ChW-1:0] cfg_mid    = MidReset;
  logic [ChW-1:0] cfg_down   = DownReset;
  logic [7:0]     frame_bytes [FrameLen];
  logic [PosW-1:0] frame_pos = '0;
  sw_pos_e        held_sw [NumSw] = '{default: SwUnset};

  rx_item_t       byte_queue [$];
  chan_result_t   expected_results [$];
  int unsigned    pushed_items   = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    send_gap = 0;
  int unsigned    recv_gap = 0;
  logic           calm    = 1'b0;
  logic           rx_hold = 1'b0;

  sbus_frame_decoder u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .frame_start_i     (frame_start_i),
    .link_lost_i       (link_lost_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .channel_index_o   (channel_index_o),
    .channel_value_o   (channel_value_o),
    .switch_position_o (switch_position_o),
    .online_o          (online_o),
    .last_o            (last_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance the frame state by one byte and queue the channel results it causes
  function automatic void decode_byte(rx_item_t item);
    logic [ChW-1:0] raw [NumCh];
    logic [23:0]    word;
    int unsigned    bitpos;
    int unsigned    s;
    logic           on;
    chan_result_t   r;
    if (item.lost) begin
      foreach (held_sw[k]) held_sw[k] = SwUnset;
      for (int k = 0; k < NumCh; k++) begin
        r.chan     = IdxW'(k);
        r.value    = '0;
        r.position = SwUnset;
        r.online   = 1'b0;
        r.last     = (k == NumCh - 1);
        expected_results.push_back(r);
      end
      return;
    end
    if (item.start) frame_pos = '0;
    if (frame_pos >= FrameLen) return;
    frame_bytes[frame_pos] = item.data;
    frame_pos++;
    if (frame_pos != FrameLen) return;
    if (frame_bytes[0] != cfg_head || frame_bytes[FrameLen-1] != cfg_tail) return;

    on = !(frame_bytes[FlagsIdx] inside {FailsafeA, FailsafeB});
    for (int k = 0; k < NumCh; k++) begin
      bitpos = k * ChW;
      s      = 1 + bitpos / 8;
      word   = {frame_bytes[s+2], frame_bytes[s+1], frame_bytes[s]};
      raw[k] = word[bitpos % 8 +: ChW];
    end
    // Up wins over mid, mid over down; the last two switches have no mid
    for (int k = 0; k < NumSw; k++) begin
      if (raw[k+NumStick] == cfg_up) held_sw[k] = SwUp;
      else if (k < 4 && raw[k+NumStick] == cfg_mid) held_sw[k] = SwMid;
      else if (raw[k+NumStick] == cfg_down) held_sw[k] = SwDown;
    end
    for (int k = 0; k < NumCh; k++) begin
      r.chan   = IdxW'(k);
      r.online = on;
      r.last   = (k == NumCh - 1);
      if (k < NumStick) begin
        r.value    = {1'b0, raw[k]} - {1'b0, cfg_offset};
        r.position = SwUnset;
      end else begin
        r.value    = {1'b0, raw[k]};
        r.position = held_sw[k-NumStick];
      end
      expected_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [ValW-1:0] want,
                                      logic [ValW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Byte driver: hold each transaction until accepted, idle in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(byte_queue.pop_front());
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (byte_queue.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 8);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i    <= 1'b1;
          rx_byte_i     <= byte_queue[0].data;
          frame_start_i <= byte_queue[0].start;
          link_lost_i   <= byte_queue[0].lost;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk_i) begin
    chan_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result for channel %0d with nothing expected", channel_index_o);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("channel_index", ValW'(want.chan), ValW'(channel_index_o));
          check_field("channel_value", want.value, channel_value_o);
          check_field("switch_position", ValW'(want.position), ValW'(switch_position_o));
          check_field("online", ValW'(want.online), ValW'(online_o));
          check_field("last", ValW'(want.last), ValW'(last_o));
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void push_byte(logic [7:0] data, logic start, logic lost);
    rx_item_t item;
    item.data  = data;
    item.start = start;
    item.lost  = lost;
    byte_queue.push_back(item);
    pushed_items++;
  endfunction

  // Queue the first len bytes of a frame; a link-lost byte goes in before lost_at
  function automatic void push_frame(logic [7:0] head, logic [7:0] tail, logic [7:0] flags,
                                     logic marked, int len, int lost_at,
                                     logic [ChW-1:0] ch [NumCh]);
    logic [7:0]             frame [FrameLen];
    logic [127:0]           rnd;
    logic [8*PackBytes-1:0] bits;
    rnd  = {$urandom, $urandom, $urandom, $urandom};
    bits = rnd[8*PackBytes-1:0];
    for (int k = 0; k < NumCh; k++) bits[k*ChW +: ChW] = ch[k];
    frame[0] = head;
    for (int i = 0; i < PackBytes; i++) frame[1+i] = bits[8*i +: 8];
    for (int i = PackBytes + 1; i < FlagsIdx; i++) frame[i] = 8'($urandom);
    frame[FlagsIdx]   = flags;
    frame[FrameLen-1] = tail;
    for (int i = 0; i < len; i++) begin
      if (i == lost_at) push_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      push_byte(frame[i], marked && i == 0, 1'b0);
    end
  endfunction

  function automatic logic [ChW-1:0] pick_code();
    case ($urandom_range(0, 5))
      0:       return cfg_up;
      1:       return cfg_mid;
      2:       return cfg_down;
      3:       return '0;
      4:       return '1;
      default: return ChW'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_flags();
    case ($urandom_range(0, 4))
      0:       return FailsafeA;
      1:       return FailsafeB;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames, the rest broken frames, link loss and noise
  function automatic void push_random(int unsigned count);
    logic [ChW-1:0] ch [NumCh];
    int unsigned    stop;
    int unsigned    r;
    int             lost_at;
    logic [7:0]     flip;
    stop = pushed_items + count;
    while (pushed_items < stop) begin
      foreach (ch[k]) ch[k] = pick_code();
      r       = $urandom_range(0, 99);
      lost_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, FrameLen - 1) : -1;
      flip    = 8'($urandom_range(1, 255));
      if (r < 55) begin
        push_frame(cfg_head, cfg_tail, pick_flags(), 1'b1, FrameLen, lost_at, ch);
      end else if (r < 63) begin
        push_frame(cfg_head ^ flip, cfg_tail, pick_flags(), 1'b1, FrameLen, -1, ch);
      end else if (r < 71) begin
        push_frame(cfg_head, cfg_tail ^ flip, pick_flags(), 1'b1, FrameLen, -1, ch);
      end else if (r < 78) begin
        push_frame(cfg_head, cfg_tail, pick_flags(), 1'b1,
                   $urandom_range(1, FrameLen - 1), -1, ch);
      end else if (r < 86) begin
        push_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      end else if (r < 93) begin
        repeat ($urandom_range(1, 3))
          push_byte(8'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      end else begin
        // bytes past the end of a frame are dropped
        push_frame(cfg_head, cfg_tail, pick_flags(), 1'b1, FrameLen, -1, ch);
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'b0);
      end
    end
  endfunction

  task automatic write_reg(cfg_reg_e which, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (which)
      CfgHead:   cfg_head   = data[7:0];
      CfgEnd:    cfg_tail   = data[7:0];
      CfgOffset: cfg_offset = data;
      CfgUp:     cfg_up     = data;
      CfgMid:    cfg_mid    = data;
      CfgDown:   cfg_down   = data;
      default:   ;
    endcase
  endtask

  task automatic write_all(logic [CfgDataW-1:0] head, logic [CfgDataW-1:0] tail,
                           logic [CfgDataW-1:0] offset, logic [CfgDataW-1:0] up,
                           logic [CfgDataW-1:0] mid, logic [CfgDataW-1:0] down);
    write_reg(CfgHead, head);
    write_reg(CfgEnd, tail);
    write_reg(CfgOffset, offset);
    write_reg(CfgUp, up);
    write_reg(CfgMid, mid);
    write_reg(CfgDown, down);
  endtask

  // Drain everything in flight, then let the pipeline settle
  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  initial begin
    logic [ChW-1:0] dir_ch [NumCh];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unmarked frame right after reset: stick extremes, every switch code,
    // mid code on a switch without a mid position, failsafe flags
    dir_ch = '{11'h000, 11'h7FF, 11'h400, 11'h3FF, UpReset, MidReset, DownReset,
               11'h7FF, MidReset, DownReset};
    push_frame(HeadReset, EndReset, FailsafeA, 1'b0, FrameLen, -1, dir_ch);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_random(30);
    wait_idle();

    // Extremes, with the 8-bit registers masked from full-width data
    write_all(11'h000, 11'h7FF, 11'h000, 11'h000, 11'h7FF, 11'h400);
    push_random(20);
    wait_idle();

    // All three switch codes equal: up takes priority
    write_all(11'h7FF, 11'h000, 11'h7FF, 11'h2AA, 11'h2AA, 11'h2AA);
    push_random(20);
    wait_idle();

    // Random settings; stall the receiver so the input backs up
    write_all(CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom),
              CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom));
    for (int i = 0; i < 3; i++) begin
      foreach (dir_ch[k]) dir_ch[k] = pick_code();
      push_frame(cfg_head, cfg_tail, pick_flags(), 1'b1, FrameLen, -1, dir_ch);
    end
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
    push_random(10);
    wait_idle();

    // Back to defaults, no idling on either side
    write_all(CfgDataW'(HeadReset), CfgDataW'(EndReset), OffsetReset, UpReset,
              MidReset, DownReset);
    calm <= 1'b1;
    push_random(20);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("sbus_frame_decoder regression: pass");
    end else begin
      $display("sbus_frame_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("sbus_frame_decoder regression: fail");
    $finish;
  end

endmodule
